FILE: design/bhte_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and controller commands of the hash table engine.
package bhte_pkg;

  localparam int SlotsPerBucket  = 8;
  localparam int MainBuckets     = 1024;
  localparam int OverflowBuckets = 256;
  localparam int NodeIndexBits   = 20;
  localparam int TotalSlots      = (MainBuckets + OverflowBuckets) * SlotsPerBucket;
  localparam int SlotW           = $clog2(SlotsPerBucket);
  localparam int BucketW         = 10;
  localparam int OvfW            = $clog2(OverflowBuckets);
  localparam int CountW          = OvfW + 1;
  localparam int AddrW           = $clog2(TotalSlots);
  localparam int PaddrW          = 3;

  localparam logic [SlotW-1:0] LinkSlot = SlotW'(SlotsPerBucket - 1);

  // Request types.
  localparam logic [1:0] ReqLookup = 2'd0;
  localparam logic [1:0] ReqInsert = 2'd1;
  localparam logic [1:0] ReqRemove = 2'd2;

  // Result status codes.
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StExists   = 2'd2;
  localparam logic [1:0] StNoSpace  = 2'd3;

  // Configuration register indexes.
  localparam logic RegBucketMask    = 1'b0;
  localparam logic RegOverflowLimit = 1'b1;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [63:0]              hash_value;
    logic [NodeIndexBits-1:0] node_index;
    logic [31:0]              new_dpo_ctx;
    logic [7:0]               new_vft;
    logic [BucketW-1:0]       loc_bucket;
    logic [SlotW-1:0]         loc_entry;
    logic                     loc_overflow;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [NodeIndexBits-1:0] found_node;
    logic [31:0]              found_dpo_ctx;
    logic [7:0]               found_vft;
    logic [SlotW-1:0]         entry_slot;
    logic [BucketW-1:0]       bucket_index;
    logic                     in_overflow;
  } res_t;

  typedef struct packed {
    logic                     is_link;
    logic [15:0]              locks;
    logic [7:0]               vft;
    logic [31:0]              ctx;
    logic [NodeIndexBits-1:0] node;
    logic [63:0]              hash;
  } slot_t;

  typedef struct packed {
    logic [BucketW-1:0] bucket_mask;
    logic [CountW-1:0]  overflow_limit;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_INIT_CLR, CMD_ACCEPT, CMD_HIT, CMD_FILL, CMD_NEXT_SLOT,
    CMD_NEXT_BUCKET, CMD_NOT_FOUND, CMD_NO_SPACE, CMD_POP, CMD_TAKE_POP,
    CMD_TAKE_FRESH, CMD_CLR_NEW, CMD_LINK, CMD_FILL_NEW, CMD_RM_CLEAR,
    CMD_WALK_START, CMD_WALK_NEXT, CMD_UNLINK
  } cmd_e;

  typedef struct packed {
    logic hit;
    logic fillable;
    logic last_slot;
    logic link_ok;
    logic step_last;
    logic is_insert;
    logic room;
    logic stack_nonempty;
    logic fresh_ok;
    logic pop_zero;
    logic k_last;
    logic rm_bad;
    logic rd_link;
    logic cur_ovf;
    logic occupied;
    logic nxt_is_loc;
    logic clear_last;
  } status_t;

  // Slot address of slot i in a main or overflow bucket.
  function automatic logic [AddrW-1:0] slot_addr(input logic ovf,
                                                 input logic [BucketW-1:0] b,
                                                 input logic [SlotW-1:0] i);
    logic [AddrW-1:0] bk;
    bk = ovf ? AddrW'(MainBuckets) + AddrW'(b) : AddrW'(b);
    return (bk << SlotW) | AddrW'(i);
  endfunction

endpackage

FILE: design/bhte_cfg.sv
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
module bhte_cfg import bhte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_beat;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;

  // Register write on the access beat.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_beat) begin
      case (paddr[2])
        RegBucketMask:    cfg_d.bucket_mask = pwdata[BucketW-1:0];
        RegOverflowLimit: cfg_d.overflow_limit = pwdata[CountW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bucket_mask    <= BucketW'(MainBuckets - 1);
      cfg_q.overflow_limit <= CountW'(OverflowBuckets);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data mux.
  always_comb begin
    case (paddr[2])
      RegBucketMask:    prdata = 32'(cfg_q.bucket_mask);
      RegOverflowLimit: prdata = 32'(cfg_q.overflow_limit);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/bhte_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps the datapath through lookup, insert and remove.
module bhte_ctrl import bhte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] req_type_i,
  input  status_t    status_i,
  output cmd_e       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  typedef enum logic [14:0] {
    ST_INIT   = 15'h0001,
    ST_IDLE   = 15'h0002,
    ST_S_WAIT = 15'h0004,
    ST_S_EVAL = 15'h0008,
    ST_A_POP  = 15'h0010,
    ST_A_CLR  = 15'h0020,
    ST_A_LINK = 15'h0040,
    ST_A_FILL = 15'h0080,
    ST_R_WAIT = 15'h0100,
    ST_R_EVAL = 15'h0200,
    ST_C_WAIT = 15'h0400,
    ST_C_EVAL = 15'h0800,
    ST_W_WAIT = 15'h1000,
    ST_W_EVAL = 15'h2000,
    ST_DONE   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // Next state and command.
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      ST_INIT: begin
        cmd_o = CMD_INIT_CLR;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o = CMD_ACCEPT;
          case (req_type_i)
            ReqLookup, ReqInsert: state_d = ST_S_WAIT;
            ReqRemove:            state_d = ST_R_WAIT;
            default:              state_d = ST_DONE;
          endcase
        end
      end
      ST_S_WAIT: state_d = ST_S_EVAL;
      ST_S_EVAL: begin
        state_d = ST_DONE;
        if (status_i.hit) begin
          cmd_o = CMD_HIT;
        end else if (status_i.fillable) begin
          cmd_o = CMD_FILL;
        end else if (!status_i.last_slot) begin
          cmd_o   = CMD_NEXT_SLOT;
          state_d = ST_S_WAIT;
        end else if (status_i.link_ok) begin
          if (status_i.step_last) begin
            cmd_o = status_i.is_insert ? CMD_NO_SPACE : CMD_NOT_FOUND;
          end else begin
            cmd_o   = CMD_NEXT_BUCKET;
            state_d = ST_S_WAIT;
          end
        end else if (!status_i.is_insert) begin
          cmd_o = CMD_NOT_FOUND;
        end else if (!status_i.room) begin
          cmd_o = CMD_NO_SPACE;
        end else if (status_i.stack_nonempty) begin
          cmd_o   = CMD_POP;
          state_d = ST_A_POP;
        end else if (status_i.fresh_ok) begin
          cmd_o   = CMD_TAKE_FRESH;
          state_d = ST_A_CLR;
        end else begin
          cmd_o = CMD_NO_SPACE;
        end
      end
      ST_A_POP: begin
        if (status_i.pop_zero) begin
          cmd_o   = CMD_NO_SPACE;
          state_d = ST_DONE;
        end else begin
          cmd_o   = CMD_TAKE_POP;
          state_d = ST_A_CLR;
        end
      end
      ST_A_CLR: begin
        cmd_o = CMD_CLR_NEW;
        if (status_i.k_last) state_d = ST_A_LINK;
      end
      ST_A_LINK: begin
        cmd_o   = CMD_LINK;
        state_d = ST_A_FILL;
      end
      ST_A_FILL: begin
        cmd_o   = CMD_FILL_NEW;
        state_d = ST_DONE;
      end
      ST_R_WAIT: state_d = ST_R_EVAL;
      ST_R_EVAL: begin
        state_d = ST_DONE;
        if (!status_i.rm_bad && !status_i.rd_link) begin
          cmd_o = CMD_RM_CLEAR;
          if (status_i.cur_ovf) state_d = ST_C_WAIT;
        end
      end
      ST_C_WAIT: state_d = ST_C_EVAL;
      ST_C_EVAL: begin
        if (status_i.occupied) begin
          state_d = ST_DONE;
        end else if (!status_i.last_slot) begin
          cmd_o   = CMD_NEXT_SLOT;
          state_d = ST_C_WAIT;
        end else begin
          cmd_o   = CMD_WALK_START;
          state_d = ST_W_WAIT;
        end
      end
      ST_W_WAIT: state_d = ST_W_EVAL;
      ST_W_EVAL: begin
        state_d = ST_DONE;
        if (status_i.link_ok) begin
          if (status_i.nxt_is_loc) begin
            cmd_o = CMD_UNLINK;
          end else if (!status_i.step_last) begin
            cmd_o   = CMD_WALK_NEXT;
            state_d = ST_W_WAIT;
          end
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

FILE: design/bhte_dp.sv
`timescale 1ns / 1ps
// Datapath: slot memory, free bucket stack, chain pointers and result register.
module bhte_dp import bhte_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_e    cmd_i,
  input  req_t    req_i,
  input  cfg_t    cfg_i,
  output status_t status_o,
  output res_t    result_o
);

  slot_t mem_q [TotalSlots];
  slot_t rd_q;
  logic [OvfW-1:0] stk_q [OverflowBuckets];
  logic [OvfW-1:0] stk_rd_q;

  req_t req_q, req_d;
  res_t res_q, res_d;
  logic [BucketW-1:0] cur_b_q, cur_b_d;
  logic               cur_ovf_q, cur_ovf_d;
  logic [SlotW-1:0]   cur_i_q, cur_i_d, k_q, k_d;
  logic [CountW-1:0]  step_q, step_d, depth_q, depth_d, fresh_q, fresh_d;
  logic [CountW-1:0]  inuse_q, inuse_d;
  logic [OvfW-1:0]    new_idx_q, new_idx_d, succ_q, succ_d;
  logic [AddrW-1:0]   clr_q, clr_d;

  logic             wr_en, stk_we;
  logic [AddrW-1:0] wr_addr, rd_addr;
  slot_t            wr_data, fill_rec, lock_rec, link_rec;
  logic [OvfW-1:0]  stk_ra, nxt;
  logic [BucketW-1:0] home_b;
  logic occ, link_ok, is_ins;

  // Decode of the slot just read.
  assign rd_addr = slot_addr(cur_ovf_q, cur_b_q, cur_i_q);
  assign occ     = !rd_q.is_link && (rd_q.hash != '0 || rd_q.node != '0);
  assign nxt     = rd_q.node[OvfW-1:0];
  assign link_ok = rd_q.is_link && rd_q.node != '0 &&
                   (rd_q.node >> OvfW) == '0;
  assign is_ins  = (req_q.req_type == ReqInsert);
  assign home_b  = req_q.hash_value[BucketW-1:0] & cfg_i.bucket_mask;
  assign stk_ra  = depth_q[OvfW-1:0] - 1'b1;

  // Records written back to the slot memory.
  always_comb begin
    fill_rec      = '0;
    fill_rec.hash = req_q.hash_value;
    fill_rec.node = req_q.node_index;
    fill_rec.ctx  = req_q.new_dpo_ctx;
    fill_rec.vft  = req_q.new_vft;
    lock_rec      = rd_q;
    if (rd_q.locks != '1) lock_rec.locks = rd_q.locks + 16'd1;
    link_rec         = '0;
    link_rec.is_link = 1'b1;
    link_rec.node    = NodeIndexBits'(new_idx_q);
  end

  // Status toward the sequencer.
  always_comb begin
    status_o.hit            = occ && rd_q.hash == req_q.hash_value;
    status_o.fillable       = is_ins && cur_i_q != LinkSlot && !rd_q.is_link && !occ;
    status_o.last_slot      = (cur_i_q == LinkSlot);
    status_o.link_ok        = link_ok;
    status_o.step_last      = (step_q == CountW'(OverflowBuckets));
    status_o.is_insert      = is_ins;
    status_o.room           = (inuse_q < cfg_i.overflow_limit);
    status_o.stack_nonempty = (depth_q != '0);
    status_o.fresh_ok       = (fresh_q < CountW'(OverflowBuckets));
    status_o.pop_zero       = (stk_rd_q == '0);
    status_o.k_last         = (k_q == LinkSlot);
    status_o.rm_bad         = req_q.loc_overflow && (req_q.loc_bucket == '0 ||
                              req_q.loc_bucket >= BucketW'(OverflowBuckets));
    status_o.rd_link        = rd_q.is_link;
    status_o.cur_ovf        = cur_ovf_q;
    status_o.occupied       = occ;
    status_o.nxt_is_loc     = (BucketW'(nxt) == req_q.loc_bucket);
    status_o.clear_last     = (clr_q == AddrW'(TotalSlots - 1));
  end

  // Command execution.
  always_comb begin
    req_d     = req_q;
    res_d     = res_q;
    cur_b_d   = cur_b_q;
    cur_ovf_d = cur_ovf_q;
    cur_i_d   = cur_i_q;
    k_d       = k_q;
    step_d    = step_q;
    depth_d   = depth_q;
    fresh_d   = fresh_q;
    inuse_d   = inuse_q;
    new_idx_d = new_idx_q;
    succ_d    = succ_q;
    clr_d     = clr_q;
    wr_en     = 1'b0;
    wr_addr   = rd_addr;
    wr_data   = '0;
    stk_we    = 1'b0;
    case (cmd_i)
      CMD_INIT_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
      end
      CMD_ACCEPT: begin
        req_d  = req_i;
        step_d = '0;
        res_d  = '0;
        res_d.status = StNotFound;
        if (req_i.req_type == ReqRemove) begin
          cur_b_d            = req_i.loc_bucket;
          cur_ovf_d          = req_i.loc_overflow;
          cur_i_d            = req_i.loc_entry;
          res_d.entry_slot   = req_i.loc_entry;
          res_d.bucket_index = req_i.loc_bucket;
          res_d.in_overflow  = req_i.loc_overflow;
        end else begin
          cur_b_d   = req_i.hash_value[BucketW-1:0] & cfg_i.bucket_mask;
          cur_ovf_d = 1'b0;
          cur_i_d   = '0;
        end
      end
      CMD_HIT, CMD_FILL: begin
        wr_en              = 1'b1;
        wr_data            = (cmd_i == CMD_HIT) ? lock_rec : fill_rec;
        res_d.status       = (cmd_i == CMD_HIT && is_ins) ? StExists : StOk;
        res_d.found_node   = wr_data.node;
        res_d.found_dpo_ctx = wr_data.ctx;
        res_d.found_vft    = wr_data.vft;
        res_d.entry_slot   = cur_i_q;
        res_d.bucket_index = cur_b_q;
        res_d.in_overflow  = cur_ovf_q;
      end
      CMD_NEXT_SLOT: cur_i_d = cur_i_q + 1'b1;
      CMD_NEXT_BUCKET: begin
        cur_b_d   = BucketW'(nxt);
        cur_ovf_d = 1'b1;
        cur_i_d   = '0;
        step_d    = step_q + 1'b1;
      end
      CMD_NOT_FOUND: begin
        res_d        = '0;
        res_d.status = StNotFound;
      end
      CMD_NO_SPACE: begin
        res_d        = '0;
        res_d.status = StNoSpace;
      end
      CMD_POP: depth_d = depth_q - 1'b1;
      CMD_TAKE_POP: begin
        new_idx_d = stk_rd_q;
        inuse_d   = inuse_q + 1'b1;
        k_d       = '0;
      end
      CMD_TAKE_FRESH: begin
        new_idx_d = fresh_q[OvfW-1:0];
        fresh_d   = fresh_q + 1'b1;
        inuse_d   = inuse_q + 1'b1;
        k_d       = '0;
      end
      CMD_CLR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = slot_addr(1'b1, BucketW'(new_idx_q), k_q);
        k_d     = k_q + 1'b1;
      end
      CMD_LINK: begin
        wr_en   = 1'b1;
        wr_addr = slot_addr(cur_ovf_q, cur_b_q, LinkSlot);
        wr_data = link_rec;
      end
      CMD_FILL_NEW: begin
        wr_en               = 1'b1;
        wr_addr             = slot_addr(1'b1, BucketW'(new_idx_q), '0);
        wr_data             = fill_rec;
        res_d.status        = StOk;
        res_d.found_node    = fill_rec.node;
        res_d.found_dpo_ctx = fill_rec.ctx;
        res_d.found_vft     = fill_rec.vft;
        res_d.entry_slot    = '0;
        res_d.bucket_index  = BucketW'(new_idx_q);
        res_d.in_overflow   = 1'b1;
      end
      CMD_RM_CLEAR: begin
        wr_en        = 1'b1;
        res_d.status = StOk;
        cur_i_d      = '0;
      end
      CMD_WALK_START: begin
        succ_d    = link_ok ? nxt : '0;
        cur_b_d   = home_b;
        cur_ovf_d = 1'b0;
        cur_i_d   = LinkSlot;
        step_d    = '0;
      end
      CMD_WALK_NEXT: begin
        cur_b_d   = BucketW'(nxt);
        cur_ovf_d = 1'b1;
        step_d    = step_q + 1'b1;
      end
      CMD_UNLINK: begin
        wr_en = 1'b1;
        if (succ_q != '0) begin
          wr_data      = rd_q;
          wr_data.node = NodeIndexBits'(succ_q);
        end
        if (depth_q < CountW'(OverflowBuckets)) begin
          stk_we  = 1'b1;
          depth_d = depth_q + 1'b1;
        end
        if (inuse_q != '0) inuse_d = inuse_q - 1'b1;
      end
      default: req_d = req_q;
    endcase
  end

  // Slot memory and free bucket stack.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
    if (stk_we) stk_q[depth_q[OvfW-1:0]] <= req_q.loc_bucket[OvfW-1:0];
    stk_rd_q <= stk_q[stk_ra];
  end

  // Pointer and result registers.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    cur_b_q   <= cur_b_d;
    cur_ovf_q <= cur_ovf_d;
    cur_i_q   <= cur_i_d;
    k_q       <= k_d;
    step_q    <= step_d;
    new_idx_q <= new_idx_d;
    succ_q    <= succ_d;
  end

  // Allocation counters and clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fresh_q <= CountW'(1);
      inuse_q <= CountW'(1);
      clr_q   <= '0;
    end else begin
      depth_q <= depth_d;
      fresh_q <= fresh_d;
      inuse_q <= inuse_d;
      clr_q   <= clr_d;
    end
  end

  assign result_o = res_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CountW'(OverflowBuckets))
    else $error("free stack depth exceeds the pool size");

  a_fresh_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q != '0)
    else $error("fresh bucket counter points at the reserved bucket");

  a_hit_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_HIT) |-> status_o.hit)
    else $error("hit command without a matching slot");

  a_alloc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_CLR_NEW) |-> (new_idx_q != '0))
    else $error("reserved overflow bucket handed out");

endmodule

FILE: design/bucketed_hash_table_engine.sv
`timescale 1ns / 1ps
// Top level of the bucketed hash table engine.
//
// After reset the engine runs a clearing pass over all 10240 slots and holds
// busy high during it; configuration writes are taken meanwhile. A
// request beat is taken when start is high and busy is low, and exactly one
// result follows, shown on result_o for the single cycle in which done_o is
// high; the receiver cannot stall it. The slot memory has one read port with
// registered data, so every slot visited passes a wait and an evaluate state. A
// lookup or insert reads the home bucket slot by slot, then walks the chain
// bucket by bucket; an insert that finds no free slot takes an overflow bucket
// from the free stack or the fresh ones, clears it, links it and fills slot 0,
// and a remove clears the slot and, in an overflow bucket, scans it for
// occupied slots and, when the bucket has emptied, unlinks it from the chain.
module bucketed_hash_table_engine import bhte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              done_o,
  output res_t              result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  cmd_e    cmd;
  status_t status;

  // Configuration registers.
  bhte_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer.
  bhte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .done_o     (done_o)
  );

  // Datapath.
  bhte_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i),
    .cfg_i    (cfg),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bucketed hash table engine.
module tb_top;
  import bhte_pkg::*;

  localparam int ClkHalf    = 4;
  localparam int CycleLimit = 3_000_000;

  // Request type that the engine does not know.
  localparam logic [1:0] ReqUnknown = 2'd3;

  // Predicts every result from its own copy of the table and checks the DUT's results.
  class hash_table_scoreboard;
    bit [63:0] tbl_hash[TotalSlots];
    bit [NodeIndexBits-1:0] tbl_node[TotalSlots];
    bit [31:0] tbl_ctx[TotalSlots];
    bit [7:0]  tbl_vft[TotalSlots];
    bit [15:0] tbl_locks[TotalSlots];
    bit        tbl_link[TotalSlots];
    bit [7:0]  pool_stack[OverflowBuckets];
    int unsigned pool_depth = 0;
    int unsigned fresh_next = 1;
    int unsigned ovf_in_use = 1;
    int unsigned mask = 1023;
    int unsigned ovf_limit = 256;
    res_t pending[$];
    int fails = 0;

    function void set_cfg(logic idx, logic [31:0] val);
      if (idx == RegBucketMask) mask = 32'(val[9:0]);
      else ovf_limit = 32'(val[8:0]);
    endfunction

    function int unsigned base_of(int unsigned b, bit ovf);
      return ovf ? (MainBuckets + b) * SlotsPerBucket : b * SlotsPerBucket;
    endfunction

    function bit occupied(int unsigned s);
      return !tbl_link[s] && (tbl_hash[s] != 0 || tbl_node[s] != 0);
    endfunction

    function void clear_slot(int unsigned s);
      tbl_hash[s] = 0; tbl_node[s] = 0; tbl_ctx[s] = 0;
      tbl_vft[s] = 0; tbl_locks[s] = 0; tbl_link[s] = 0;
    endfunction

    function int unsigned next_link(int unsigned base);
      int unsigned s;
      s = base + LinkSlot;
      if (tbl_link[s] && tbl_node[s] >= 1 && tbl_node[s] < OverflowBuckets)
        return 32'(tbl_node[s]);
      return 0;
    endfunction

    function res_t slot_result(logic [1:0] st, int unsigned s, int unsigned i,
                               int unsigned b, bit ovf);
      res_t r;
      r.status = st; r.found_node = tbl_node[s]; r.found_dpo_ctx = tbl_ctx[s];
      r.found_vft = tbl_vft[s]; r.entry_slot = SlotW'(i); r.bucket_index = BucketW'(b);
      r.in_overflow = ovf;
      return r;
    endfunction

    function res_t empty_result(logic [1:0] st);
      res_t r;
      r = '0;
      r.status = st;
      return r;
    endfunction

    function void fill(int unsigned s, req_t q);
      clear_slot(s);
      tbl_hash[s] = q.hash_value; tbl_node[s] = q.node_index;
      tbl_ctx[s] = q.new_dpo_ctx; tbl_vft[s] = q.new_vft;
    endfunction

    // Takes an overflow bucket from the free pool or from the fresh ones; zero on failure.
    function int unsigned take_bucket();
      int unsigned idx, i, base;
      if (ovf_in_use >= ovf_limit) return 0;
      if (pool_depth > 0) begin
        pool_depth--;
        idx = 32'(pool_stack[pool_depth]);
        if (idx == 0) return 0;
      end else if (fresh_next < OverflowBuckets) begin
        idx = fresh_next++;
      end else begin
        return 0;
      end
      ovf_in_use++;
      base = base_of(idx, 1);
      for (i = 0; i < SlotsPerBucket; i++) clear_slot(base + i);
      return idx;
    endfunction

    function res_t search_chain(req_t q, bit ins);
      int unsigned b, base, s, i, nxt, idx, step;
      bit ovf;
      b = q.hash_value[9:0] & mask;
      ovf = 0;
      for (step = 0; step <= OverflowBuckets; step++) begin
        base = base_of(b, ovf);
        for (i = 0; i < SlotsPerBucket; i++) begin
          s = base + i;
          if (occupied(s) && tbl_hash[s] == q.hash_value) begin
            if (tbl_locks[s] != 16'hFFFF) tbl_locks[s]++;
            return slot_result(ins ? StExists : StOk, s, i, b, ovf);
          end
          if (ins && i != LinkSlot && !tbl_link[s] && !occupied(s)) begin
            fill(s, q);
            return slot_result(StOk, s, i, b, ovf);
          end
        end
        nxt = next_link(base);
        if (nxt == 0) begin
          if (!ins) return empty_result(StNotFound);
          idx = take_bucket();
          if (idx == 0) return empty_result(StNoSpace);
          s = base + LinkSlot;
          clear_slot(s);
          tbl_link[s] = 1;
          tbl_node[s] = NodeIndexBits'(idx);
          s = base_of(idx, 1);
          fill(s, q);
          return slot_result(StOk, s, 0, idx, 1);
        end
        b = nxt;
        ovf = 1;
      end
      return empty_result(ins ? StNoSpace : StNotFound);
    endfunction

    // Clears a slot; an emptied overflow bucket is unlinked from the hash's chain.
    function res_t remove_entry(req_t q);
      res_t r;
      int unsigned b, base, s, i, cnt, pbase, nxt, succ, step;
      bit ovf;
      r = '0;
      r.status = StNotFound; r.entry_slot = q.loc_entry;
      r.bucket_index = q.loc_bucket; r.in_overflow = q.loc_overflow;
      ovf = q.loc_overflow;
      b = 32'(q.loc_bucket);
      if (ovf && (b == 0 || b >= OverflowBuckets)) return r;
      base = base_of(b, ovf);
      s = base + q.loc_entry;
      if (tbl_link[s]) return r;
      clear_slot(s);
      r.status = StOk;
      if (!ovf) return r;
      cnt = 0;
      for (i = 0; i < SlotsPerBucket; i++) if (occupied(base + i)) cnt++;
      if (cnt > 0) return r;
      pbase = base_of(q.hash_value[9:0] & mask, 0);
      for (step = 0; step <= OverflowBuckets; step++) begin
        nxt = next_link(pbase);
        if (nxt == 0) break;
        if (nxt == b) begin
          succ = next_link(base);
          if (succ != 0) tbl_node[pbase + LinkSlot] = NodeIndexBits'(succ);
          else clear_slot(pbase + LinkSlot);
          if (pool_depth < OverflowBuckets) pool_stack[pool_depth++] = 8'(b);
          if (ovf_in_use > 0) ovf_in_use--;
          break;
        end
        pbase = base_of(nxt, 1);
      end
      return r;
    endfunction

    // Notes an accepted request beat and queues the result it must cause.
    function res_t note_request(req_t q);
      res_t r;
      case (q.req_type)
        ReqLookup: r = search_chain(q, 0);
        ReqInsert: r = search_chain(q, 1);
        ReqRemove: r = remove_entry(q);
        default:   r = empty_result(StNotFound);
      endcase
      pending.push_back(r);
      return r;
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fails++;
      end
    endfunction

    // Checks a result beat against the oldest expected result.
    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $error("result beat with no request outstanding");
        fails++;
        return;
      end
      want = pending.pop_front();
      compare("status", want.status, got.status);
      compare("found_node", want.found_node, got.found_node);
      compare("found_dpo_ctx", want.found_dpo_ctx, got.found_dpo_ctx);
      compare("found_vft", want.found_vft, got.found_vft);
      compare("entry_slot", want.entry_slot, got.entry_slot);
      compare("bucket_index", want.bucket_index, got.bucket_index);
      compare("in_overflow", want.in_overflow, got.in_overflow);
    endfunction
  endclass

  typedef struct {
    logic [63:0]        hash;
    logic [BucketW-1:0] bucket;
    logic [SlotW-1:0]   slot;
    logic               ovf;
  } live_entry_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  res_t result_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hash_table_scoreboard sb = new();
  live_entry_t live_entries[$];
  logic [63:0] hash_pool[96];
  int unsigned cycle_count = 0;

  bucketed_hash_table_engine DUT (.*);

  always begin
    #ClkHalf clk_i = 1;
    #ClkHalf clk_i = 0;
  end

  // Result beats are taken at every rising edge with done high.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** bucketed_hash_table_engine: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    sb.set_cfg(idx, val);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Waits until every expected result has come back, plus a little slack.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Drives one request beat and tracks live entries for later removals.
  task automatic send_request(req_t q, int unsigned gap);
    res_t r;
    @(negedge clk_i);
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk_i);
    end
    req_i = q;
    start = 1;
    do @(posedge clk_i); while (busy);
    r = sb.note_request(q);
    if (q.req_type == ReqInsert && r.status == StOk &&
        !(q.hash_value == 0 && q.node_index == 0))
      live_entries.push_back('{q.hash_value, r.bucket_index, r.entry_slot, r.in_overflow});
    if (q.req_type == ReqRemove && r.status == StOk)
      foreach (live_entries[k])
        if (live_entries[k].bucket == q.loc_bucket && live_entries[k].slot == q.loc_entry &&
            live_entries[k].ovf == q.loc_overflow) begin
          live_entries.delete(k);
          break;
        end
  endtask

  function automatic req_t random_request();
    req_t q;
    logic [159:0] rnd;
    int unsigned pick, k;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
    q = rnd[$bits(req_t)-1:0];
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 8) q.hash_value = hash_pool[$urandom_range(0, 95)];
    if (pick < 40) begin
      q.req_type = ReqInsert;
    end else if (pick < 68) begin
      q.req_type = ReqLookup;
    end else if (pick < 95) begin
      q.req_type = ReqRemove;
      if (live_entries.size() > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, live_entries.size() - 1);
        q.hash_value = live_entries[k].hash;
        q.loc_bucket = live_entries[k].bucket;
        q.loc_entry = live_entries[k].slot;
        q.loc_overflow = live_entries[k].ovf;
      end
    end else begin
      q.req_type = ReqUnknown;
    end
    return q;
  endfunction

  // One phase: new register values, then random traffic at a given idle rate.
  task automatic run_phase(int unsigned n, int unsigned idle_pct,
                           logic [31:0] mask, logic [31:0] limit);
    int unsigned gap;
    drain();
    write_reg(RegBucketMask, mask);
    write_reg(RegOverflowLimit, limit);
    foreach (hash_pool[k]) begin
      hash_pool[k] = {$urandom, $urandom};
      hash_pool[k][9:0] = 10'($urandom_range(0, 15));
    end
    for (int i = 0; i < n; i++) begin
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 20) : 0;
      send_request(random_request(), gap);
    end
    @(negedge clk_i);
    start = 0;
  endtask

  initial begin
    req_t q;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed part: one small table, one usable overflow bucket.
    write_reg(RegBucketMask, 7);
    write_reg(RegOverflowLimit, 2);
    q = '0;
    q.hash_value = 64'h3 | (64'd1 << 20);
    send_request(q, 0);
    // Fill the main bucket, then the overflow bucket, then run out of space.
    for (int k = 1; k <= 15; k++) begin
      q = '0;
      q.req_type = ReqInsert;
      q.hash_value = 64'h3 | (64'(k) << 20);
      q.node_index = k[0] ? '1 : NodeIndexBits'(k);
      q.new_dpo_ctx = k[0] ? 32'hFFFF_FFFF : $urandom;
      q.new_vft = k[0] ? 8'hFF : 8'(k);
      send_request(q, 0);
    end
    // Existing entry and a hit in the overflow bucket.
    q.hash_value = 64'h3 | (64'd2 << 20);
    send_request(q, 0);
    q.req_type = ReqLookup;
    q.hash_value = 64'h3 | (64'd10 << 20);
    send_request(q, 0);
    // Removal of the link slot, of overflow bucket zero, and out of range.
    q = '0;
    q.req_type = ReqRemove;
    q.loc_bucket = 3;
    q.loc_entry = LinkSlot;
    send_request(q, 0);
    q.loc_overflow = 1;
    q.loc_bucket = 0;
    send_request(q, 0);
    q = '1;
    q.req_type = ReqRemove;
    send_request(q, 0);
    q = '1;
    send_request(q, 0);
    // Zero hash with zero node leaves the slot empty.
    q = '0;
    q.req_type = ReqInsert;
    send_request(q, 0);
    q.node_index = 5;
    send_request(q, 0);
    q.req_type = ReqLookup;
    send_request(q, 0);
    @(negedge clk_i);
    start = 0;

    run_phase(450, 0, 1023, 256);
    run_phase(400, 66, 7, 2);
    run_phase(450, 0, 15, 5);
    run_phase(400, 38, 7, 256);

    drain();
    if (sb.fails == 0) begin
      $display("** bucketed_hash_table_engine: PASSED **");
    end else begin
      $display("** bucketed_hash_table_engine: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bhte_pkg.sv
design/bhte_cfg.sv
design/bhte_ctrl.sv
design/bhte_dp.sv
design/bucketed_hash_table_engine.sv
verif/tb_top.sv
